// ===== hw/rtl/cfd_pkg.sv =====
// Shared types, codes and constants for the command frame deframer.
package cfd_pkg;

	localparam logic [7:0] MIN_LENGTH = 8'd3;

	localparam logic [7:0] CMD_F2 = 8'hf2;
	localparam logic [7:0] CMD_2F = 8'h2f;
	localparam logic [7:0] CMD_F6 = 8'hf6;
	localparam logic [7:0] CMD_6F = 8'h6f;
	localparam logic [7:0] CMD_F9 = 8'hf9;
	localparam logic [7:0] CMD_9F = 8'h9f;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_LEN     = 3'd1,
		PH_TYPE    = 3'd2,
		PH_REG     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CSUM    = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		K_COMMAND  = 3'd0,
		K_LENGTH   = 3'd1,
		K_TYPE     = 3'd2,
		K_REGISTER = 3'd3,
		K_PAYLOAD  = 3'd4,
		K_CHECKSUM = 3'd5,
		K_DISCARD  = 3'd6,
		K_BADLEN   = 3'd7
	} kind_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] frame_length;
		logic [7:0] bytes_remaining;
		logic [7:0] running_sum;
	} state_t;

	typedef struct packed {
		logic [7:0] byte_value;
		kind_t      kind;
		logic [7:0] payload_index;
		logic       frame_end;
		logic       checksum_ok;
	} result_t;

	function automatic logic is_start_code(input logic [7:0] b);
		return (b == CMD_F2) || (b == CMD_2F) || (b == CMD_F6) ||
			(b == CMD_6F) || (b == CMD_F9) || (b == CMD_9F);
	endfunction

endpackage

// ===== hw/rtl/cfd_step.sv =====
// Per-byte frame decode: next state and tagged result for one received byte.
module cfd_step (
	input  logic [7:0]      rx_byte,
	input  cfd_pkg::state_t cur,
	output cfd_pkg::state_t nxt,
	output cfd_pkg::result_t res
);
	import cfd_pkg::*;

	logic [7:0] sum_add;
	logic [7:0] body_len;
	logic [7:0] rem_dec;

	assign sum_add  = cur.running_sum + rx_byte;
	assign body_len = cur.frame_length - MIN_LENGTH;
	assign rem_dec  = cur.bytes_remaining - 8'd1;

	always_comb begin
		nxt               = cur;
		res.byte_value    = rx_byte;
		res.kind          = K_DISCARD;
		res.payload_index = 8'd0;
		res.frame_end     = 1'b0;
		res.checksum_ok   = 1'b0;
		case (cur.phase)
			PH_LEN: begin
				if (rx_byte < MIN_LENGTH) begin
					res.kind      = K_BADLEN;
					res.frame_end = 1'b1;
					nxt.phase     = PH_HUNT;
				end else begin
					res.kind         = K_LENGTH;
					nxt.frame_length = rx_byte;
					nxt.running_sum  = sum_add;
					nxt.phase        = PH_TYPE;
				end
			end
			PH_TYPE: begin
				res.kind        = K_TYPE;
				nxt.running_sum = sum_add;
				nxt.phase       = PH_REG;
			end
			PH_REG: begin
				res.kind            = K_REGISTER;
				nxt.running_sum     = sum_add;
				nxt.bytes_remaining = body_len;
				nxt.phase           = (body_len == 8'd0) ? PH_CSUM : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				res.kind            = K_PAYLOAD;
				res.payload_index   = body_len - cur.bytes_remaining;
				nxt.running_sum     = sum_add;
				nxt.bytes_remaining = rem_dec;
				if (rem_dec == 8'd0) begin
					nxt.phase = PH_CSUM;
				end
			end
			PH_CSUM: begin
				res.kind        = K_CHECKSUM;
				res.frame_end   = 1'b1;
				res.checksum_ok = (rx_byte == cur.running_sum);
				nxt.phase       = PH_HUNT;
			end
			default: begin
				// hunt: only a command byte opens a frame
				if (is_start_code(rx_byte)) begin
					res.kind        = K_COMMAND;
					nxt.running_sum = rx_byte;
					nxt.phase       = PH_LEN;
				end else begin
					res.kind  = K_DISCARD;
					nxt.phase = PH_HUNT;
				end
			end
		endcase
	end

endmodule

// ===== hw/rtl/command_frame_deframer.sv =====
// Command frame deframer top level: input register, frame decode, result register.
//
//  channel   | dir | tdata                              | tuser                   | tlast
//  s_*       | in  | [7:0] rx_byte                      | -                       | -
//  m_*       | out | [7:0] byte_value, [15:8] pay. idx  | [2:0] kind, [3] cks ok  | frame_end
//
// One byte per cycle sustained while the result is not stalled; a byte's result passes
// through the input register, then is decoded into the result register and offered.
// The frame state (phase, length, remaining count, running sum) updates as a
// byte moves from the input register into the result register.
// Reset returns to hunting with length, count and sum cleared.
// A stalled result holds; the input register still takes one more byte.
module command_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] byte_value, [15:8] payload_index
	output logic [3:0]  m_tuser,   // [2:0] kind, [3] checksum_ok
	output logic        m_tlast    // frame_end
);
	import cfd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    res_s2;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res_nxt;
	logic       advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	cfd_step u_step (
		.rx_byte (byte_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{phase: PH_HUNT, frame_length: 8'd0,
				bytes_remaining: 8'd0, running_sum: 8'd0};
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.payload_index, res_s2.byte_value};
	assign m_tuser  = {res_s2.checksum_ok, res_s2.kind};
	assign m_tlast  = res_s2.frame_end;

	// frame end only on a checksum or a bad length byte
	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.frame_end) |->
			(res_s2.kind == K_CHECKSUM || res_s2.kind == K_BADLEN))
		else $error("frame end on a non-terminal byte");

	a_ok_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.checksum_ok) |-> (res_s2.kind == K_CHECKSUM))
		else $error("checksum ok outside a checksum byte");

	a_pidx_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.payload_index != 8'd0) |-> (res_s2.kind == K_PAYLOAD))
		else $error("payload index on a non-payload byte");

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_PAYLOAD) |-> (state_q.bytes_remaining != 8'd0))
		else $error("payload phase with no bytes left");

	// a command byte always leads into the length phase
	a_cmd_next: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_nxt.kind == K_COMMAND) |=> (state_q.phase == PH_LEN))
		else $error("command byte did not open a frame");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for command_frame_deframer: directed frames, random streams, backpressure.
`timescale 1ns / 100ps

module tb_top;
	import cfd_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 5;
	localparam int LONG_HOLD    = 300;
	localparam int RANDOM_ITEMS = 650;
	localparam int MAX_PRINTED  = 30;

	typedef enum int {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;   // [7:0] byte_value, [15:8] payload_index
	logic [3:0]  m_tuser;   // [2:0] kind, [3] checksum_ok
	logic        m_tlast;   // frame_end

	command_frame_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Frame tracker mirrored from the block's behavior
	phase_t     trk_phase;
	logic [7:0] trk_length;
	logic [7:0] trk_remaining;
	logic [7:0] trk_sum;

	result_t tagged_bytes_due[$];
	int      kind_count[8];
	int      mismatches;
	int      bytes_sent;
	int      bytes_checked;

	logic [7:0] cmd_codes[6];

	// Sender and receiver pacing
	bit       sender_gaps;
	int       burst_left;
	rx_mode_t rx_mode;
	int       hold_requests;
	int       holds_taken;
	int       hold_left;
	logic [10:0] rx_pattern;

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(CLK_PERIOD * 400000);
		$display("timeout: %0d beats still due", tagged_bytes_due.size());
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic is_command(input logic [7:0] b);
		logic hit;
		hit = 1'b0;
		foreach (cmd_codes[i])
			if (cmd_codes[i] == b)
				hit = 1'b1;
		return hit;
	endfunction

	// Advance the frame tracker by one byte and return the tagged result
	function automatic result_t decode_byte(input logic [7:0] b);
		result_t r;
		r.byte_value = b;
		r.kind = K_DISCARD;
		r.payload_index = 8'd0;
		r.frame_end = 1'b0;
		r.checksum_ok = 1'b0;
		case (trk_phase)
			PH_LEN: begin
				if (b < MIN_LENGTH) begin
					r.kind = K_BADLEN;
					r.frame_end = 1'b1;
					trk_phase = PH_HUNT;
				end else begin
					r.kind = K_LENGTH;
					trk_length = b;
					trk_sum = trk_sum + b;
					trk_phase = PH_TYPE;
				end
			end
			PH_TYPE: begin
				r.kind = K_TYPE;
				trk_sum = trk_sum + b;
				trk_phase = PH_REG;
			end
			PH_REG: begin
				r.kind = K_REGISTER;
				trk_sum = trk_sum + b;
				trk_remaining = trk_length - MIN_LENGTH;
				trk_phase = (trk_remaining == 8'd0) ? PH_CSUM : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				r.kind = K_PAYLOAD;
				trk_sum = trk_sum + b;
				r.payload_index = (trk_length - MIN_LENGTH) - trk_remaining;
				trk_remaining = trk_remaining - 8'd1;
				if (trk_remaining == 8'd0)
					trk_phase = PH_CSUM;
			end
			PH_CSUM: begin
				r.kind = K_CHECKSUM;
				r.frame_end = 1'b1;
				r.checksum_ok = (b == trk_sum);
				trk_phase = PH_HUNT;
			end
			default: begin
				// unused phase codes fall back to hunting
				if (is_command(b)) begin
					r.kind = K_COMMAND;
					trk_sum = b;
					trk_phase = PH_LEN;
				end else begin
					r.kind = K_DISCARD;
					trk_phase = PH_HUNT;
				end
			end
		endcase
		kind_count[r.kind]++;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("[%0t] mismatch on beat %0d: %s got 0x%0h, want 0x%0h",
				$time, bytes_checked, what, got, want);
	endtask

	// Offer one byte, pausing between bursts when gaps are enabled
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_gaps ? $urandom_range(1, 7) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		tagged_bytes_due.push_back(decode_byte(b));
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_noise_byte();
		logic [7:0] b;
		b = 8'($urandom);
		while (is_command(b)) b = 8'($urandom);
		send_byte(b);
	endtask

	// Send one frame; a length below the minimum stops after the length byte
	task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len, input bit bad_sum);
		logic [7:0] sum;
		logic [7:0] b;
		sum = cmd;
		send_byte(cmd);
		send_byte(len);
		if (len < MIN_LENGTH)
			return;
		sum = sum + len;
		for (int i = 0; i < 2 + int'(len) - 3; i++) begin
			b = 8'($urandom);
			sum = sum + b;
			send_byte(b);
		end
		if (bad_sum)
			sum = sum ^ (8'd1 << $urandom_range(0, 7));
		send_byte(sum);
	endtask

	function automatic logic [7:0] random_command();
		return cmd_codes[$urandom_range(0, 5)];
	endfunction

	task automatic wait_for_drain(input int settle);
		while (tagged_bytes_due.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
	endtask

	// Extremes of the byte, every command code, each bad length, empty and short payloads
	task automatic test_directed();
		sender_gaps = 1'b0;
		rx_mode = RX_ALWAYS;
		send_byte(8'h00);
		send_byte(8'hff);
		send_frame(CMD_F2, 8'd0, 1'b0);
		send_frame(CMD_2F, 8'd1, 1'b0);
		send_frame(CMD_F6, 8'd2, 1'b0);
		send_frame(CMD_6F, 8'd3, 1'b0);
		send_frame(CMD_F9, 8'd5, 1'b1);
		send_frame(CMD_9F, 8'd2, 1'b0);
		stop_sending();
		wait_for_drain(4);
	endtask

	// Mostly well-formed frames with random content, plus noise and broken frames
	task automatic test_random_stream(input int items, input rx_mode_t mode);
		int start;
		int pick;
		int len;
		bit long_done;
		start = bytes_sent;
		long_done = 1'b0;
		sender_gaps = 1'b1;
		rx_mode = mode;
		while (bytes_sent - start < items) begin
			pick = $urandom_range(0, 99);
			if (!long_done && bytes_sent - start > items / 2 && mode == RX_RANDOM) begin
				// one frame at the largest length
				send_frame(random_command(), 8'd255, 1'b0);
				long_done = 1'b1;
			end else if (pick < 65) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(3, 10);
				send_frame(random_command(), len[7:0], 1'b0);
			end else if (pick < 75) begin
				send_frame(random_command(), 8'($urandom_range(3, 12)), 1'b1);
			end else if (pick < 83) begin
				send_frame(random_command(), 8'($urandom_range(0, 2)), 1'b0);
			end else if (pick < 93) begin
				repeat ($urandom_range(1, 4)) send_noise_byte();
			end else begin
				// cut a frame short; the tracker keeps counting into what follows
				send_byte(random_command());
				repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
			end
		end
		stop_sending();
		wait_for_drain(4);
	endtask

	// Hold the receiver off for a long stretch while bytes keep coming
	task automatic test_backpressure();
		sender_gaps = 1'b0;
		rx_mode = RX_ALWAYS;
		hold_requests++;
		@(posedge clk);
		repeat (6) send_frame(random_command(), 8'($urandom_range(3, 8)), 1'b0);
		stop_sending();
		wait_for_drain(4);
	endtask

	// Receiver: long hold when asked, otherwise the current stall mode
	initial begin : receiver
		rx_pattern = 11'b101100111_01;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_taken) begin
				holds_taken++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: m_tready <= 1'b1;
					RX_RANDOM: m_tready <= ($urandom_range(0, 9) < 6);
					default: begin
						m_tready <= rx_pattern[0];
						rx_pattern = {rx_pattern[0], rx_pattern[10:1]};
					end
				endcase
			end
		end
	end

	// Compare each delivered beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (tagged_bytes_due.size() == 0) begin
				report_mismatch("beat with nothing due, tdata", m_tdata, 0);
			end else begin : compare
				result_t want;
				want = tagged_bytes_due.pop_front();
				if (m_tdata[7:0] !== want.byte_value)
					report_mismatch("byte_value", m_tdata[7:0], want.byte_value);
				if (m_tuser[2:0] !== want.kind)
					report_mismatch("kind", m_tuser[2:0], want.kind);
				if (m_tdata[15:8] !== want.payload_index)
					report_mismatch("payload_index", m_tdata[15:8], want.payload_index);
				if (m_tlast !== want.frame_end)
					report_mismatch("frame_end", m_tlast, want.frame_end);
				if (m_tuser[3] !== want.checksum_ok)
					report_mismatch("checksum_ok", m_tuser[3], want.checksum_ok);
			end
			bytes_checked++;
		end
	end

	initial begin
		cmd_codes = '{CMD_F2, CMD_2F, CMD_F6, CMD_6F, CMD_F9, CMD_9F};
		trk_phase = PH_HUNT;
		trk_length = 8'd0;
		trk_remaining = 8'd0;
		trk_sum = 8'd0;
		mismatches = 0;
		bytes_sent = 0;
		bytes_checked = 0;
		burst_left = 0;
		sender_gaps = 1'b0;
		rx_mode = RX_ALWAYS;
		hold_requests = 0;
		holds_taken = 0;
		hold_left = 0;
		foreach (kind_count[i]) kind_count[i] = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_random_stream(RANDOM_ITEMS * 2 / 3, RX_RANDOM);
		test_backpressure();
		test_random_stream(RANDOM_ITEMS / 3, RX_PATTERN);

		wait_for_drain(10);
		$display("Covered %0d bytes: %0d frames closed by checksum, %0d bad lengths,",
			bytes_checked, kind_count[K_CHECKSUM], kind_count[K_BADLEN]);
		$display("  %0d payload bytes, %0d discarded, with gaps, stalls and a long hold.",
			kind_count[K_PAYLOAD], kind_count[K_DISCARD]);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/cfd_pkg.sv
hw/rtl/cfd_step.sv
hw/rtl/command_frame_deframer.sv
tb/tb_top.sv
